// ===== hdl/rmv_pkg.sv =====
// Package for the running mean / variance / min / max unit.
// Holds widths, command and status codes, the transaction structs and
// the controller-to-datapath command and status types. No dependencies.
`default_nettype none

package rmv_pkg;

  // Field widths.
  localparam int COUNT_BITS  = 32;
  localparam int SAMPLE_BITS = 32;
  localparam int FRAC_BITS   = 16;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int M2_W        = 64;
  localparam int INV_W       = 32;
  localparam int STD_W       = 32;

  // Internal widths.
  localparam int MEAN_W  = SAMPLE_BITS + FRAC_BITS;  // mean with F fraction bits
  localparam int AD_W    = MEAN_W;                   // magnitude of a mean difference
  localparam int MUL_A_W = M2_W;
  localparam int MUL_B_W = AD_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DVD_W   = AD_W + COUNT_BITS;
  localparam int DVS_W   = COUNT_BITS;

  localparam logic [COUNT_BITS-1:0]  COUNT_MAX = '1;
  localparam logic [INV_W-1:0]       INV_MAX   = '1;
  localparam logic [SAMPLE_BITS-1:0] SMP_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMP_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MERGE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]              cmd;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          sample_valid;
    logic [COUNT_BITS-1:0]         src_count;
    logic signed [SAMPLE_BITS-1:0] src_mean;
    logic [M2_W-1:0]               src_m2;
    logic signed [SAMPLE_BITS-1:0] src_min;
    logic signed [SAMPLE_BITS-1:0] src_max;
    logic [INV_W-1:0]              src_invalid;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]           status;
    logic [COUNT_BITS-1:0]         sample_count;
    logic signed [SAMPLE_BITS-1:0] running_mean;
    logic [M2_W-1:0]               sum_sq_dev;
    logic [M2_W-1:0]               sample_variance;
    logic [STD_W-1:0]              std_deviation;
    logic signed [SAMPLE_BITS-1:0] min_seen;
    logic signed [SAMPLE_BITS-1:0] max_seen;
    logic [INV_W-1:0]              invalid_count;
  } rsp_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_APPLY,
    OP_DIFF,
    OP_DIV_ADD,
    OP_MEAN_ADD,
    OP_MUL_ADD,
    OP_FIN_ADD,
    OP_MUL_M1,
    OP_DIV_M,
    OP_MUL_M2,
    OP_MUL_M3,
    OP_FIN_M,
    OP_DIV_VAR,
    OP_VAR_LATCH,
    OP_VAR_ZERO,
    OP_SQRT,
    OP_OUT
  } dp_op_t;

  // Which long update a command needs.
  typedef enum logic [1:0] {
    PATH_NONE,
    PATH_ADD,
    PATH_MERGE
  } path_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    path_t path;
    logic  need_var;
    logic  mul_done;
    logic  div_done;
    logic  sqrt_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/rmv_if.sv =====
// Request and response channel interfaces of the statistics unit.
// Each carries valid, ready and the payload; depends on rmv_pkg.
`default_nettype none

interface rmv_req_if;
  import rmv_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              cmd;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          sample_valid;
  logic [COUNT_BITS-1:0]         src_count;
  logic signed [SAMPLE_BITS-1:0] src_mean;
  logic [M2_W-1:0]               src_m2;
  logic signed [SAMPLE_BITS-1:0] src_min;
  logic signed [SAMPLE_BITS-1:0] src_max;
  logic [INV_W-1:0]              src_invalid;

  modport source (
    output valid, cmd, sample_value, sample_valid, src_count, src_mean, src_m2,
           src_min, src_max, src_invalid,
    input  ready
  );
  modport sink (
    input  valid, cmd, sample_value, sample_valid, src_count, src_mean, src_m2,
           src_min, src_max, src_invalid,
    output ready
  );
endinterface

interface rmv_rsp_if;
  import rmv_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [STATUS_W-1:0]           status;
  logic [COUNT_BITS-1:0]         sample_count;
  logic signed [SAMPLE_BITS-1:0] running_mean;
  logic [M2_W-1:0]               sum_sq_dev;
  logic [M2_W-1:0]               sample_variance;
  logic [STD_W-1:0]              std_deviation;
  logic signed [SAMPLE_BITS-1:0] min_seen;
  logic signed [SAMPLE_BITS-1:0] max_seen;
  logic [INV_W-1:0]              invalid_count;

  modport source (
    output valid, status, sample_count, running_mean, sum_sq_dev, sample_variance,
           std_deviation, min_seen, max_seen, invalid_count,
    input  ready
  );
  modport sink (
    input  valid, status, sample_count, running_mean, sum_sq_dev, sample_variance,
           std_deviation, min_seen, max_seen, invalid_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/rmv_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on rmv_pkg for the operand widths.
`default_nettype none

module rmv_mul (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [rmv_pkg::MUL_A_W-1:0] a,
  input  wire logic [rmv_pkg::MUL_B_W-1:0] b,
  output logic [rmv_pkg::PROD_W-1:0]       prod,
  output logic                             done
);
  import rmv_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);

  logic [MUL_A_W-1:0] a_reg;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [MUL_A_W:0]   sum;

  // Add the multiplicand into the upper half when the low bit is set.
  assign sum = {1'b0, prod[PROD_W-1 -: MUL_A_W]} + (prod[0] ? {1'b0, a_reg} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  // Product register holds the multiplier in its low bits and shifts right.
  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      prod  <= {{MUL_A_W{1'b0}}, b};
      cnt   <= CNT_W'(MUL_B_W - 1);
    end else if (busy) begin
      prod <= {sum, prod[MUL_B_W-1:1]};
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rmv_div.sv =====
// Restoring divider, one quotient bit per cycle, with round-half-up output.
// Depends on rmv_pkg for the dividend and divisor widths.
`default_nettype none

module rmv_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [rmv_pkg::DVD_W-1:0] dividend,
  input  wire logic [rmv_pkg::DVS_W-1:0] divisor,
  output logic [rmv_pkg::DVD_W-1:0]      quo_rnd,
  output logic                           done
);
  import rmv_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   trial;
  logic             ge;

  // One restoring step.
  assign trial = {rem, quo[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  // Round to nearest, ties up: bump when twice the remainder reaches the divisor.
  assign quo_rnd = quo + DVD_W'({rem, 1'b0} >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  // Quotient bits shift in from the right as dividend bits shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      cnt <= CNT_W'(DVD_W - 1);
    end else if (busy) begin
      rem <= ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rmv_dp.sv =====
// Datapath of the statistics unit: state registers, update arithmetic,
// the shared multiplier and divider, and a digit-serial square root.
// Depends on rmv_pkg, rmv_mul and rmv_div.
`default_nettype none

module rmv_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rmv_pkg::req_t    req_data,
  input  wire rmv_pkg::dp_cmd_t cmd,
  output rmv_pkg::dp_sts_t      sts,
  output rmv_pkg::rsp_t         rsp_data
);
  import rmv_pkg::*;

  localparam int SH = 2 * FRAC_BITS;

  // Round a product right by 2F bits and saturate it to 64 bits.
  function automatic logic [M2_W-1:0] rsat(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] s;
    s = {1'b0, p} + {{(PROD_W-SH+1){1'b0}}, 1'b1, {(SH-1){1'b0}}};
    if (|s[PROD_W:SH+M2_W]) rsat = '1;
    else rsat = s[SH+M2_W-1:SH];
  endfunction

  function automatic logic [M2_W-1:0] sat_add(input logic [M2_W-1:0] a,
                                              input logic [M2_W-1:0] b);
    logic [M2_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[M2_W] ? '1 : s[M2_W-1:0];
  endfunction

  // State and working registers.
  req_t                      in_reg;
  logic [COUNT_BITS-1:0]     count_reg;
  logic signed [MEAN_W-1:0]  mean_reg;
  logic [M2_W-1:0]           m2_reg;
  logic signed [SAMPLE_BITS-1:0] min_reg;
  logic signed [SAMPLE_BITS-1:0] max_reg;
  logic [INV_W-1:0]          invalid_reg;
  logic [STATUS_W-1:0]       status_reg;
  logic [AD_W-1:0]           ad_reg;
  logic                      dneg_reg;
  logic [AD_W-1:0]           r_reg;
  logic [M2_W-1:0]           var_reg;
  rsp_t                      out_reg;

  // Square root registers.
  logic [M2_W-1:0] sq_v;
  logic [M2_W-1:0] sq_res;
  logic [M2_W-1:0] sq_bit;
  logic            sq_busy;
  logic            sq_done;

  // Shared units.
  logic              mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic              mul_done;
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic [DVD_W-1:0]  quo_rnd;
  logic              div_done;

  // Derived values.
  logic signed [MEAN_W-1:0] xs;
  logic signed [MEAN_W-1:0] smean;
  logic signed [MEAN_W-1:0] dsel;
  logic signed [MEAN_W:0]   diff;
  logic signed [MEAN_W:0]   diff2;
  logic [AD_W-1:0]          ad2;
  logic [COUNT_BITS-1:0]    n_next;
  logic [COUNT_BITS:0]      total33;
  logic                     merge_ovf;
  logic [INV_W:0]           inv_sum;
  logic [AD_W-1:0]          qa;
  logic [MEAN_W:0]          mean_rnd;
  logic [M2_W-1:0]          w_sat;
  logic [M2_W-1:0]          sq_t;
  logic                     x_lt_min;
  logic                     x_gt_max;

  assign xs    = {in_reg.sample_value, {FRAC_BITS{1'b0}}};
  assign smean = {in_reg.src_mean, {FRAC_BITS{1'b0}}};
  assign dsel  = (in_reg.cmd == CMD_ADD) ? xs : smean;
  assign diff  = {dsel[MEAN_W-1], dsel} - {mean_reg[MEAN_W-1], mean_reg};
  assign diff2 = {xs[MEAN_W-1], xs} - {mean_reg[MEAN_W-1], mean_reg};
  assign ad2   = diff2[MEAN_W] ? AD_W'(-diff2) : diff2[AD_W-1:0];

  assign n_next    = count_reg + 1'b1;
  assign total33   = {1'b0, count_reg} + {1'b0, in_reg.src_count};
  assign merge_ovf = (in_reg.src_count != '0) && (count_reg != '0) && total33[COUNT_BITS];
  assign inv_sum   = {1'b0, invalid_reg} + {1'b0, in_reg.src_invalid};
  assign qa        = quo_rnd[AD_W-1:0];
  assign mean_rnd  = {mean_reg[MEAN_W-1], mean_reg}
                     + {{(MEAN_W-FRAC_BITS+1){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  assign w_sat     = (|prod[PROD_W-1:M2_W]) ? '1 : prod[M2_W-1:0];
  assign sq_t      = sq_res + sq_bit;
  assign x_lt_min  = $signed(in_reg.sample_value) < $signed(min_reg);
  assign x_gt_max  = $signed(in_reg.sample_value) > $signed(max_reg);

  // Status back to the controller.
  always_comb begin
    sts.path = PATH_NONE;
    if (in_reg.cmd == CMD_ADD && in_reg.sample_valid && count_reg != COUNT_MAX) begin
      sts.path = PATH_ADD;
    end else if (in_reg.cmd == CMD_MERGE && !merge_ovf && in_reg.src_count != '0 &&
                 count_reg != '0) begin
      sts.path = PATH_MERGE;
    end
    sts.need_var  = |count_reg[COUNT_BITS-1:1];
    sts.mul_done  = mul_done;
    sts.div_done  = div_done;
    sts.sqrt_done = sq_done;
  end

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = {{(MUL_A_W-AD_W){1'b0}}, ad_reg};
    mul_b     = ad2;
    div_start = 1'b0;
    div_dvd   = {{(DVD_W-AD_W){1'b0}}, ad_reg};
    div_dvs   = n_next;
    case (cmd.op)
      OP_DIV_ADD: begin
        div_start = 1'b1;
      end
      OP_MUL_ADD: begin
        mul_start = 1'b1;
      end
      OP_MUL_M1: begin
        mul_start = 1'b1;
        mul_b     = MUL_B_W'(in_reg.src_count);
      end
      OP_DIV_M: begin
        div_start = 1'b1;
        div_dvd   = prod[DVD_W-1:0];
        div_dvs   = total33[COUNT_BITS-1:0];
      end
      OP_MUL_M2: begin
        mul_start = 1'b1;
        mul_b     = qa;
      end
      OP_MUL_M3: begin
        mul_start = 1'b1;
        mul_a     = rsat(prod);
        mul_b     = MUL_B_W'(count_reg);
      end
      OP_DIV_VAR: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(m2_reg);
        div_dvs   = count_reg - 1'b1;
      end
      default: begin
      end
    endcase
  end

  rmv_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .done  (mul_done)
  );

  rmv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quo_rnd  (quo_rnd),
    .done     (div_done)
  );

  // Accumulator state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg   <= '0;
      mean_reg    <= '0;
      m2_reg      <= '0;
      min_reg     <= SMP_MAX;
      max_reg     <= SMP_MIN;
      invalid_reg <= '0;
    end else begin
      case (cmd.op)
        OP_APPLY: begin
          case (in_reg.cmd)
            CMD_ADD: begin
              if (!in_reg.sample_valid && invalid_reg != INV_MAX) begin
                invalid_reg <= invalid_reg + 1'b1;
              end
            end
            CMD_MERGE: begin
              if (!merge_ovf) begin
                invalid_reg <= inv_sum[INV_W] ? INV_MAX : inv_sum[INV_W-1:0];
                if (in_reg.src_count != '0 && count_reg == '0) begin
                  count_reg <= in_reg.src_count;
                  mean_reg  <= smean;
                  m2_reg    <= in_reg.src_m2;
                  min_reg   <= in_reg.src_min;
                  max_reg   <= in_reg.src_max;
                end
              end
            end
            CMD_CLEAR: begin
              count_reg   <= '0;
              mean_reg    <= '0;
              m2_reg      <= '0;
              min_reg     <= SMP_MAX;
              max_reg     <= SMP_MIN;
              invalid_reg <= '0;
            end
            default: begin
            end
          endcase
        end
        OP_MEAN_ADD: begin
          mean_reg <= dneg_reg ? mean_reg - MEAN_W'(qa) : mean_reg + MEAN_W'(qa);
        end
        OP_FIN_ADD: begin
          m2_reg    <= sat_add(m2_reg, rsat(prod));
          if (count_reg == '0 || x_lt_min) min_reg <= in_reg.sample_value;
          if (count_reg == '0 || x_gt_max) max_reg <= in_reg.sample_value;
          count_reg <= n_next;
        end
        OP_FIN_M: begin
          m2_reg    <= sat_add(sat_add(m2_reg, in_reg.src_m2), w_sat);
          mean_reg  <= dneg_reg ? mean_reg - MEAN_W'(r_reg) : mean_reg + MEAN_W'(r_reg);
          count_reg <= total33[COUNT_BITS-1:0];
          if ($signed(in_reg.src_min) < $signed(min_reg)) min_reg <= in_reg.src_min;
          if ($signed(in_reg.src_max) > $signed(max_reg)) max_reg <= in_reg.src_max;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers that carry no reset.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        in_reg <= req_data;
      end
      OP_APPLY: begin
        if (in_reg.cmd == CMD_ADD && !in_reg.sample_valid) begin
          status_reg <= ST_INVALID;
        end else if (in_reg.cmd == CMD_ADD && count_reg == COUNT_MAX) begin
          status_reg <= ST_OVERFLOW;
        end else if (in_reg.cmd == CMD_MERGE && merge_ovf) begin
          status_reg <= ST_OVERFLOW;
        end else begin
          status_reg <= ST_OK;
        end
      end
      OP_DIFF: begin
        dneg_reg <= diff[MEAN_W];
        ad_reg   <= diff[MEAN_W] ? AD_W'(-diff) : diff[AD_W-1:0];
      end
      OP_MUL_M2: begin
        r_reg <= qa;
      end
      OP_VAR_LATCH: begin
        var_reg <= quo_rnd[M2_W-1:0];
      end
      OP_VAR_ZERO: begin
        var_reg <= '0;
      end
      OP_OUT: begin
        out_reg.status          <= status_reg;
        out_reg.sample_count    <= count_reg;
        out_reg.running_mean    <= mean_rnd[MEAN_W-1:FRAC_BITS];
        out_reg.sum_sq_dev      <= m2_reg;
        out_reg.sample_variance <= var_reg;
        out_reg.std_deviation   <= sq_res[STD_W-1:0];
        out_reg.min_seen        <= min_reg;
        out_reg.max_seen        <= max_reg;
        out_reg.invalid_count   <= invalid_reg;
      end
      default: begin
      end
    endcase
  end

  // Square root, one result bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
    end else begin
      if (cmd.op == OP_SQRT) begin
        sq_busy <= 1'b1;
        sq_done <= 1'b0;
      end else if (sq_busy && sq_bit[0]) begin
        sq_busy <= 1'b0;
        sq_done <= 1'b1;
      end else begin
        sq_done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQRT) begin
      sq_v   <= var_reg;
      sq_res <= '0;
      sq_bit <= {2'b01, {(M2_W-2){1'b0}}};
    end else if (sq_busy) begin
      if (sq_v >= sq_t) begin
        sq_v   <= sq_v - sq_t;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  assign rsp_data = out_reg;

endmodule

`default_nettype wire

// ===== hdl/rmv_ctrl.sv =====
// Controller of the statistics unit: sequences the datapath operations
// for each command and runs both handshakes. Depends on rmv_pkg.
`default_nettype none

module rmv_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  input  wire rmv_pkg::dp_sts_t sts,
  output rmv_pkg::dp_cmd_t      cmd
);
  import rmv_pkg::*;

  localparam int ST_W = 25;

  typedef enum logic [ST_W-1:0] {
    S_IDLE    = ST_W'(1) << 0,
    S_APPLY   = ST_W'(1) << 1,
    S_A_DIFF  = ST_W'(1) << 2,
    S_A_DIV   = ST_W'(1) << 3,
    S_A_DWAIT = ST_W'(1) << 4,
    S_A_MEAN  = ST_W'(1) << 5,
    S_A_MUL   = ST_W'(1) << 6,
    S_A_MWAIT = ST_W'(1) << 7,
    S_A_FIN   = ST_W'(1) << 8,
    S_M_DIFF  = ST_W'(1) << 9,
    S_M_MUL1  = ST_W'(1) << 10,
    S_M_W1    = ST_W'(1) << 11,
    S_M_DIV   = ST_W'(1) << 12,
    S_M_W2    = ST_W'(1) << 13,
    S_M_MUL2  = ST_W'(1) << 14,
    S_M_W3    = ST_W'(1) << 15,
    S_M_MUL3  = ST_W'(1) << 16,
    S_M_W4    = ST_W'(1) << 17,
    S_M_FIN   = ST_W'(1) << 18,
    S_VAR     = ST_W'(1) << 19,
    S_V_WAIT  = ST_W'(1) << 20,
    S_V_LATCH = ST_W'(1) << 21,
    S_SQ      = ST_W'(1) << 22,
    S_SQ_WAIT = ST_W'(1) << 23,
    S_OUT     = ST_W'(1) << 24
  } state_t;

  state_t state;
  state_t state_next;
  logic   can_load;

  assign req_ready = (state == S_IDLE);
  assign can_load  = !rsp_valid || rsp_ready;

  // Next state and datapath operation.
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.op = OP_APPLY;
        case (sts.path)
          PATH_ADD:   state_next = S_A_DIFF;
          PATH_MERGE: state_next = S_M_DIFF;
          default:    state_next = S_VAR;
        endcase
      end
      S_A_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = S_A_DIV;
      end
      S_A_DIV: begin
        cmd.op     = OP_DIV_ADD;
        state_next = S_A_DWAIT;
      end
      S_A_DWAIT: begin
        if (sts.div_done) state_next = S_A_MEAN;
      end
      S_A_MEAN: begin
        cmd.op     = OP_MEAN_ADD;
        state_next = S_A_MUL;
      end
      S_A_MUL: begin
        cmd.op     = OP_MUL_ADD;
        state_next = S_A_MWAIT;
      end
      S_A_MWAIT: begin
        if (sts.mul_done) state_next = S_A_FIN;
      end
      S_A_FIN: begin
        cmd.op     = OP_FIN_ADD;
        state_next = S_VAR;
      end
      S_M_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = S_M_MUL1;
      end
      S_M_MUL1: begin
        cmd.op     = OP_MUL_M1;
        state_next = S_M_W1;
      end
      S_M_W1: begin
        if (sts.mul_done) state_next = S_M_DIV;
      end
      S_M_DIV: begin
        cmd.op     = OP_DIV_M;
        state_next = S_M_W2;
      end
      S_M_W2: begin
        if (sts.div_done) state_next = S_M_MUL2;
      end
      S_M_MUL2: begin
        cmd.op     = OP_MUL_M2;
        state_next = S_M_W3;
      end
      S_M_W3: begin
        if (sts.mul_done) state_next = S_M_MUL3;
      end
      S_M_MUL3: begin
        cmd.op     = OP_MUL_M3;
        state_next = S_M_W4;
      end
      S_M_W4: begin
        if (sts.mul_done) state_next = S_M_FIN;
      end
      S_M_FIN: begin
        cmd.op     = OP_FIN_M;
        state_next = S_VAR;
      end
      S_VAR: begin
        if (sts.need_var) begin
          cmd.op     = OP_DIV_VAR;
          state_next = S_V_WAIT;
        end else begin
          cmd.op     = OP_VAR_ZERO;
          state_next = S_SQ;
        end
      end
      S_V_WAIT: begin
        if (sts.div_done) state_next = S_V_LATCH;
      end
      S_V_LATCH: begin
        cmd.op     = OP_VAR_LATCH;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op     = OP_SQRT;
        state_next = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (sts.sqrt_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (can_load) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && can_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/running_mean_variance_minmax_unit.sv =====
// Running mean / variance / min / max unit, top level.
// One transaction at a time. Each response waits on the 80-step divider, the 48-step
// multiplier and the 32-step square root as its command needs them, and the variance
// divide is skipped while fewer than two samples are held. The response register
// frees the request side the cycle after a result is loaded.
// Synchronous reset empties the statistics and drops any pending response.
`default_nettype none

module running_mean_variance_minmax_unit (
  input wire logic  clk,
  input wire logic  rst,
  rmv_req_if.sink   req,
  rmv_rsp_if.source rsp
);
  import rmv_pkg::*;

  req_t    req_data;
  rsp_t    rsp_data;
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Gather the request payload.
  assign req_data.cmd          = req.cmd;
  assign req_data.sample_value = req.sample_value;
  assign req_data.sample_valid = req.sample_valid;
  assign req_data.src_count    = req.src_count;
  assign req_data.src_mean     = req.src_mean;
  assign req_data.src_m2       = req.src_m2;
  assign req_data.src_min      = req.src_min;
  assign req_data.src_max      = req.src_max;
  assign req_data.src_invalid  = req.src_invalid;

  rmv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  rmv_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .cmd      (dp_cmd),
    .sts      (dp_sts),
    .rsp_data (rsp_data)
  );

  // Spread the response payload.
  assign rsp.status          = rsp_data.status;
  assign rsp.sample_count    = rsp_data.sample_count;
  assign rsp.running_mean    = rsp_data.running_mean;
  assign rsp.sum_sq_dev      = rsp_data.sum_sq_dev;
  assign rsp.sample_variance = rsp_data.sample_variance;
  assign rsp.std_deviation   = rsp_data.std_deviation;
  assign rsp.min_seen        = rsp_data.min_seen;
  assign rsp.max_seen        = rsp_data.max_seen;
  assign rsp.invalid_count   = rsp_data.invalid_count;

  // An accepted request keeps the unit busy for at least the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while a previous one is in progress");

  // Fewer than two samples give a zero variance.
  a_var_small: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.sample_count < 2) |-> rsp.sample_variance == '0)
    else $error("nonzero variance reported for fewer than two samples");

  // An empty accumulator reports its reset statistics.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.sample_count == '0 |->
      rsp.sum_sq_dev == '0 && rsp.min_seen == SMP_MAX && rsp.max_seen == SMP_MIN)
    else $error("empty accumulator reports non-reset statistics");

endmodule

`default_nettype wire
